>>> rtl/core/lds_pkg.sv
// Shared types and constants for the serial LED refresh block.
`default_nettype none

package lds_pkg;

    localparam int COUNT_W    = 5;   // byte counts and positions, up to 16
    localparam int TICK_W     = 5;   // tick within a byte, 0..24
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h80;

    // last tick of a byte: 8 bits x 3 ticks, then the trailing tick
    localparam logic [TICK_W-1:0] BYTE_TAIL_TICK = 5'd24;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_CLEAR   = 2'd1,
        FUNC_REFRESH = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTENSITY   = 2'd0,
        CFG_DISPLAY_ON  = 2'd1,
        CFG_REVERSE     = 2'd2,
        CFG_DIGIT_COUNT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START1 = 4'd1,
        ST_CMD    = 4'd2,
        ST_STOP1  = 4'd3,
        ST_START2 = 4'd4,
        ST_ADDR   = 4'd5,
        ST_DATA   = 4'd6,
        ST_STOP2  = 4'd7,
        ST_START3 = 4'd8,
        ST_CTRL   = 4'd9,
        ST_STOP3  = 4'd10
    } t_stage;

    typedef struct packed {
        logic [2:0]         intensity;
        logic               display_on;
        logic               reverse_order;
        logic [COUNT_W-1:0] digit_count;
    } t_cfg;

    typedef struct packed {
        logic busy_now;
        logic clk_next;
        logic din_next;
        logic busy_next;
        logic done;
    } t_seq_status;

endpackage

`default_nettype wire

>>> rtl/core/lds_ifs.sv
// Handshake channels: request items, result items and register writes.
`default_nettype none

interface lds_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] index;
    logic [7:0] value;

    modport source(output valid, func, index, value, input ready);
    modport sink(input valid, func, index, value, output ready);
endinterface

interface lds_result_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic din_level;
    logic busy_res;
    logic accepted;
    logic frame_done;

    modport source(output valid, clk_level, din_level, busy_res, accepted, frame_done,
                   input ready);
    modport sink(input valid, clk_level, din_level, busy_res, accepted, frame_done,
                 output ready);
endinterface

interface lds_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lds_pkg::CFG_IDX_W-1:0]  index;
    logic [lds_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lds_memory.sv
// Display memory: segment bytes with byte write, full clear and one read port.
`default_nettype none

module lds_memory #(
    parameter int MEMORY_BYTES = 16,
    localparam int ADDR_W = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire logic [7:0]          i_wr_data,
    input  wire logic                i_clear,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output logic      [7:0]          o_rd_data
);

    logic [7:0] r_mem [MEMORY_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MEMORY_BYTES; i++) begin
                r_mem[i] <= 8'h00;
            end
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[i_rd_addr];

endmodule

`default_nettype wire

>>> rtl/core/lds_sequencer.sv
// Pin sequencer: start, byte and stop phases of the three refresh frames.
`default_nettype none

module lds_sequencer #(
    parameter int MEMORY_BYTES = 16,
    localparam int ADDR_W = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_step,
    input  wire lds_pkg::t_cfg        i_cfg,
    output logic      [ADDR_W-1:0]    o_rd_addr,
    input  wire logic [7:0]           i_rd_data,
    output lds_pkg::t_seq_status      o_status
);

    localparam logic [lds_pkg::COUNT_W-1:0] MB_COUNT = MEMORY_BYTES[lds_pkg::COUNT_W-1:0];

    lds_pkg::t_stage                 r_stage, n_stage;
    logic [lds_pkg::TICK_W-1:0]      r_tick, n_tick;
    logic [1:0]                      r_phase, n_phase;
    logic [lds_pkg::COUNT_W-1:0]     r_pos, n_pos;
    logic [7:0]                      r_shift, n_shift;
    logic                            r_clk, n_clk;
    logic                            r_din, n_din;
    logic                            done;

    logic [lds_pkg::COUNT_W-1:0]     count;
    logic [lds_pkg::COUNT_W-1:0]     addr_full;
    logic [lds_pkg::COUNT_W-1:0]     pos_inc;
    logic [7:0]                      send_byte;
    logic [7:0]                      byte_src;
    logic                            byte_end;

    assign count     = (i_cfg.digit_count > MB_COUNT) ? MB_COUNT : i_cfg.digit_count;
    assign addr_full = i_cfg.reverse_order ? (count - 5'd1 - r_pos) : r_pos;
    assign o_rd_addr = addr_full[ADDR_W-1:0];
    assign pos_inc   = r_pos + 5'd1;
    assign byte_end  = (r_tick >= lds_pkg::BYTE_TAIL_TICK);

    always_comb begin
        case (r_stage)
            lds_pkg::ST_CMD:  send_byte = lds_pkg::CMD_DATA;
            lds_pkg::ST_ADDR: send_byte = lds_pkg::CMD_ADDR;
            lds_pkg::ST_CTRL: send_byte = lds_pkg::CMD_CTRL
                                        | {4'h0, i_cfg.display_on, i_cfg.intensity};
            default:          send_byte = (r_pos < count) ? i_rd_data : 8'h00;
        endcase
    end

    // shift byte is loaded on the first tick of each byte
    assign byte_src = (r_tick == '0) ? send_byte : r_shift;

    // next stage
    always_comb begin
        n_stage = r_stage;
        if (i_start) begin
            n_stage = lds_pkg::ST_START1;
        end else if (i_step) begin
            case (r_stage)
                lds_pkg::ST_IDLE: n_stage = lds_pkg::ST_IDLE;
                lds_pkg::ST_START1: if (r_tick >= 5'd2) n_stage = lds_pkg::ST_CMD;
                lds_pkg::ST_START2: if (r_tick >= 5'd2) n_stage = lds_pkg::ST_ADDR;
                lds_pkg::ST_START3: if (r_tick >= 5'd2) n_stage = lds_pkg::ST_CTRL;
                lds_pkg::ST_STOP1:  if (r_tick >= 5'd2) n_stage = lds_pkg::ST_START2;
                lds_pkg::ST_STOP2:  if (r_tick >= 5'd2) n_stage = lds_pkg::ST_START3;
                lds_pkg::ST_STOP3:  if (r_tick >= 5'd2) n_stage = lds_pkg::ST_IDLE;
                lds_pkg::ST_CMD:    if (byte_end) n_stage = lds_pkg::ST_STOP1;
                lds_pkg::ST_CTRL:   if (byte_end) n_stage = lds_pkg::ST_STOP3;
                lds_pkg::ST_ADDR: begin
                    if (byte_end) begin
                        n_stage = (count != '0) ? lds_pkg::ST_DATA : lds_pkg::ST_STOP2;
                    end
                end
                lds_pkg::ST_DATA: begin
                    if (byte_end && pos_inc >= count) n_stage = lds_pkg::ST_STOP2;
                end
                default: n_stage = lds_pkg::ST_IDLE;
            endcase
        end
    end

    // lines, counters and shift byte
    always_comb begin
        n_tick  = r_tick;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_shift = r_shift;
        n_clk   = r_clk;
        n_din   = r_din;
        done    = 1'b0;
        if (i_start) begin
            n_tick  = '0;
            n_phase = 2'd0;
            n_pos   = '0;
        end else if (i_step) begin
            case (r_stage)
                lds_pkg::ST_IDLE: ;
                lds_pkg::ST_START1, lds_pkg::ST_START2, lds_pkg::ST_START3: begin
                    n_tick = r_tick + 5'd1;
                    if (r_tick == 5'd0) begin
                        n_clk = 1'b1;
                        n_din = 1'b1;
                    end else if (r_tick == 5'd1) begin
                        n_din = 1'b0;
                    end else begin
                        n_clk  = 1'b0;
                        n_tick = '0;
                    end
                end
                lds_pkg::ST_STOP1, lds_pkg::ST_STOP2, lds_pkg::ST_STOP3: begin
                    n_tick = r_tick + 5'd1;
                    if (r_tick == 5'd0) begin
                        n_clk = 1'b0;
                        n_din = 1'b0;
                    end else if (r_tick == 5'd1) begin
                        n_clk = 1'b1;
                    end else begin
                        n_din  = 1'b1;
                        n_tick = '0;
                        done   = (r_stage == lds_pkg::ST_STOP3);
                    end
                end
                lds_pkg::ST_CMD, lds_pkg::ST_ADDR, lds_pkg::ST_DATA, lds_pkg::ST_CTRL: begin
                    if (!byte_end) begin
                        n_tick  = r_tick + 5'd1;
                        n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                        n_shift = byte_src;
                        case (r_phase)
                            2'd0: n_clk = 1'b0;
                            2'd1: begin
                                n_din   = byte_src[0];
                                n_shift = {1'b0, byte_src[7:1]};
                            end
                            default: n_clk = 1'b1;
                        endcase
                    end else begin
                        n_clk   = 1'b0;
                        n_din   = 1'b0;
                        n_tick  = '0;
                        n_phase = 2'd0;
                        if (r_stage == lds_pkg::ST_ADDR) begin
                            n_pos = '0;
                        end else if (r_stage == lds_pkg::ST_DATA) begin
                            n_pos = (pos_inc >= count) ? '0 : pos_inc;
                        end
                    end
                end
                default: begin
                    n_tick  = '0;
                    n_phase = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= lds_pkg::ST_IDLE;
            r_tick  <= '0;
            r_phase <= 2'd0;
            r_pos   <= '0;
            r_shift <= 8'h00;
            r_clk   <= 1'b1;
            r_din   <= 1'b1;
        end else begin
            r_stage <= n_stage;
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_clk   <= n_clk;
            r_din   <= n_din;
        end
    end

    // busy_now, clk_next, din_next, busy_next, done
    assign o_status = {(r_stage != lds_pkg::ST_IDLE), n_clk, n_din,
                       (n_stage != lds_pkg::ST_IDLE), done};

endmodule

`default_nettype wire

>>> rtl/core/led_driver_serial_refresh.sv
// Top level: serial refresh engine for a two-wire LED driver.
//
// Request beats arrive on i_item: func selects byte write, memory clear,
// refresh start or one pin tick; index and value carry a byte write.
// Every request beat yields exactly one result beat on o_result with the
// clock and data pin levels, busy, accepted and frame_done.
// Register writes come on i_cfg (intensity, display on, reverse order,
// digit count); the port is always ready and writes take effect next cycle.
// The sequencer and memory update at the request beat and the result is
// held in an output register. Throughput is one beat per cycle; the output
// register lets a new beat in whenever it is empty or being drained, so a
// stalled receiver stalls i_item only while its result is pending. A full
// refresh with N digits takes 6 * 3 + (N + 3) * 25 ticks.
// Reset drives both pins high, clears the display memory, goes idle and
// loads intensity 7, display on, forward order and 16 digits.
`default_nettype none

module led_driver_serial_refresh #(
    parameter int MEMORY_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lds_item_if.sink        i_item,
    lds_result_if.source    o_result,
    lds_cfg_if.sink         i_cfg
);

    localparam int ADDR_W = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
    localparam logic [lds_pkg::COUNT_W-1:0] MB_COUNT = MEMORY_BYTES[lds_pkg::COUNT_W-1:0];

    lds_pkg::t_cfg        r_cfg;
    lds_pkg::t_seq_status status;
    lds_pkg::t_func       func;

    logic              accept;
    logic              idle_req;
    logic              wr_en;
    logic              clr_en;
    logic              start;
    logic              step;
    logic              acc;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic r_out_valid;
    logic r_clk_level;
    logic r_din_level;
    logic r_busy_res;
    logic r_accepted;
    logic r_frame_done;

    assign func         = lds_pkg::t_func'(i_item.func);
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign idle_req     = accept && !status.busy_now;

    assign wr_en  = idle_req && (func == lds_pkg::FUNC_WRITE)
                  && ({1'b0, i_item.index} < MB_COUNT);
    assign clr_en = idle_req && (func == lds_pkg::FUNC_CLEAR);
    assign start  = idle_req && (func == lds_pkg::FUNC_REFRESH);
    assign step   = accept && (func == lds_pkg::FUNC_TICK);
    assign acc    = wr_en || clr_en || start;

    lds_memory #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_memory (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_item.index[ADDR_W-1:0]),
        .i_wr_data (i_item.value),
        .i_clear   (clr_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lds_sequencer #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_sequencer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_step    (step),
        .i_cfg     (r_cfg),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_status  (status)
    );

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intensity     <= 3'd7;
            r_cfg.display_on    <= 1'b1;
            r_cfg.reverse_order <= 1'b0;
            r_cfg.digit_count   <= 5'd16;
        end else if (i_cfg.valid) begin
            case (lds_pkg::t_cfg_idx'(i_cfg.index))
                lds_pkg::CFG_INTENSITY:   r_cfg.intensity     <= i_cfg.data[2:0];
                lds_pkg::CFG_DISPLAY_ON:  r_cfg.display_on    <= i_cfg.data[0];
                lds_pkg::CFG_REVERSE:     r_cfg.reverse_order <= i_cfg.data[0];
                lds_pkg::CFG_DIGIT_COUNT: r_cfg.digit_count   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_clk_level  <= status.clk_next;
            r_din_level  <= status.din_next;
            r_busy_res   <= status.busy_next;
            r_accepted   <= acc;
            r_frame_done <= status.done;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.clk_level  = r_clk_level;
    assign o_result.din_level  = r_din_level;
    assign o_result.busy_res   = r_busy_res;
    assign o_result.accepted   = r_accepted;
    assign o_result.frame_done = r_frame_done;

endmodule

`default_nettype wire
